### design/running_sample_statistics_unit_macros.svh
// Assertion helpers for the running sample statistics unit.
`ifndef RUNNING_SAMPLE_STATISTICS_UNIT_MACROS_SVH
`define RUNNING_SAMPLE_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/rss_pkg.sv
`timescale 1ns / 1ps
package rss_pkg;

    localparam logic [15:0] MAX_SAMPLES = 16'd65535;

    localparam int MDIV_STEPS = 24;
    localparam int VDIV_STEPS = 48;
    localparam int SQRT_STEPS = 24;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_UPDATE    = 4'd1;
    localparam logic [3:0] OP_LOAD      = 4'd2;
    localparam logic [3:0] OP_MUL_SQ    = 4'd3;
    localparam logic [3:0] OP_MUL_LO    = 4'd4;
    localparam logic [3:0] OP_MUL_HI    = 4'd5;
    localparam logic [3:0] OP_ADD_HI    = 4'd6;
    localparam logic [3:0] OP_SUB       = 4'd7;
    localparam logic [3:0] OP_MDIV_INIT = 4'd8;
    localparam logic [3:0] OP_DIV_STEP  = 4'd9;
    localparam logic [3:0] OP_VDIV_INIT = 4'd10;
    localparam logic [3:0] OP_SQRT_INIT = 4'd11;
    localparam logic [3:0] OP_SQRT_STEP = 4'd12;
    localparam logic [3:0] OP_RESULT    = 4'd13;

    typedef struct packed {
        logic               action;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic               is_empty;
        logic               dropped;
        logic [15:0]        count;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [15:0]        spread;
        logic signed [23:0] mean_q8;
        logic [22:0]        sdev_q8;
    } t_out_item;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic empty;
    } t_status;

endpackage

### design/rss_ctrl.sv
`timescale 1ns / 1ps
module rss_ctrl
    import rss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_LOAD   = 4'd2;
    localparam logic [3:0] ST_MSQ    = 4'd3;
    localparam logic [3:0] ST_MLO    = 4'd4;
    localparam logic [3:0] ST_MHI    = 4'd5;
    localparam logic [3:0] ST_ADD    = 4'd6;
    localparam logic [3:0] ST_SUB    = 4'd7;
    localparam logic [3:0] ST_MINIT  = 4'd8;
    localparam logic [3:0] ST_MDIV   = 4'd9;
    localparam logic [3:0] ST_VINIT  = 4'd10;
    localparam logic [3:0] ST_VDIV   = 4'd11;
    localparam logic [3:0] ST_SINIT  = 4'd12;
    localparam logic [3:0] ST_SQRT   = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_UPDATE;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = i_status.empty ? ST_OUT : ST_LOAD;
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = ST_MSQ;
            end
            ST_MSQ: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = ST_MLO;
            end
            ST_MLO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.op = OP_ADD_HI;
                n_state  = ST_SUB;
            end
            ST_SUB: begin
                o_cmd.op = OP_SUB;
                n_state  = ST_MINIT;
            end
            ST_MINIT: begin
                o_cmd.op = OP_MDIV_INIT;
                n_cnt    = 6'(MDIV_STEPS - 1);
                n_state  = ST_MDIV;
            end
            ST_MDIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_VINIT;
                end
            end
            ST_VINIT: begin
                o_cmd.op = OP_VDIV_INIT;
                n_cnt    = 6'(VDIV_STEPS - 1);
                n_state  = ST_VDIV;
            end
            ST_VDIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_SINIT;
                end
            end
            ST_SINIT: begin
                o_cmd.op = OP_SQRT_INIT;
                n_cnt    = 6'(SQRT_STEPS - 1);
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/rss_datapath.sv
`timescale 1ns / 1ps
module rss_datapath
    import rss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_item,
    output t_status   o_status,
    output t_out_item o_out_item
);

    logic [15:0]        r_count;
    logic signed [15:0] r_min;
    logic signed [15:0] r_max;
    logic signed [32:0] r_sum;
    logic [45:0]        r_ssq;
    logic               r_dropped;

    logic               r_neg;
    logic [31:0]        r_smag;
    logic [61:0]        r_sumsqr;
    logic [61:0]        r_dvar;
    logic [29:0]        r_prod;
    logic [31:0]        r_nsq;
    logic [31:0]        r_div;
    logic [31:0]        r_drem;
    logic [47:0]        r_dq;
    logic signed [23:0] r_mean;
    logic [25:0]        r_srem;
    logic [23:0]        r_root;
    t_out_item          r_out;

    logic signed [31:0] w_sq;
    logic [31:0]        w_mul_a, w_mul_b;
    logic [63:0]        w_mul_p;
    logic [32:0]        w_dt;
    logic               w_dge;
    logic [27:0]        w_rs, w_trial;
    logic               w_sge;

    assign w_sq = i_in_item.sample * i_in_item.sample;

    always_comb begin
        w_mul_a = r_smag;
        w_mul_b = r_smag;
        case (i_cmd.op)
            OP_MUL_LO: begin
                w_mul_a = {16'd0, r_count};
                w_mul_b = r_ssq[31:0];
            end
            OP_MUL_HI: begin
                w_mul_a = {16'd0, r_count};
                w_mul_b = {18'd0, r_ssq[45:32]};
            end
            OP_SUB: begin
                w_mul_a = {16'd0, r_count};
                w_mul_b = {16'd0, r_count};
            end
            default: begin
                w_mul_a = r_smag;
                w_mul_b = r_smag;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_dt    = {r_drem, r_dq[47]};
    assign w_dge   = (w_dt >= {1'b0, r_div});
    assign w_rs    = {r_srem, r_dq[47:46]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = (w_rs >= w_trial);

    assign o_status.empty = (r_count == 16'd0);
    assign o_out_item     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 16'd0;
            r_min     <= '0;
            r_max     <= '0;
            r_sum     <= '0;
            r_ssq     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.op == OP_UPDATE) begin
            if (i_in_item.action) begin
                r_count   <= 16'd0;
                r_min     <= '0;
                r_max     <= '0;
                r_sum     <= '0;
                r_ssq     <= '0;
                r_dropped <= 1'b0;
            end else if (r_count >= MAX_SAMPLES) begin
                r_dropped <= 1'b1;
            end else begin
                r_dropped <= 1'b0;
                r_count   <= r_count + 16'd1;
                if (r_count == 16'd0 || i_in_item.sample < r_min) begin
                    r_min <= i_in_item.sample;
                end
                if (r_count == 16'd0 || i_in_item.sample > r_max) begin
                    r_max <= i_in_item.sample;
                end
                r_sum <= r_sum + 33'(i_in_item.sample);
                r_ssq <= r_ssq + {14'd0, $unsigned(w_sq)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_neg  <= r_sum[32];
                r_smag <= r_sum[32] ? 32'(-r_sum) : r_sum[31:0];
            end
            OP_MUL_SQ: r_sumsqr <= w_mul_p[61:0];
            OP_MUL_LO: r_dvar   <= w_mul_p[61:0];
            OP_MUL_HI: r_prod   <= w_mul_p[29:0];
            OP_ADD_HI: r_dvar   <= r_dvar + {r_prod, 32'd0};
            OP_SUB: begin
                r_dvar <= (r_dvar >= r_sumsqr) ? r_dvar - r_sumsqr : 62'd0;
                r_nsq  <= w_mul_p[31:0];
            end
            OP_MDIV_INIT: begin
                r_div  <= {16'd0, r_count};
                r_drem <= {16'd0, r_smag[31:16]};
                r_dq   <= {r_smag[15:0], 32'd0};
            end
            OP_DIV_STEP: begin
                r_drem <= w_dge ? 32'(w_dt - {1'b0, r_div}) : w_dt[31:0];
                r_dq   <= {r_dq[46:0], w_dge};
            end
            OP_VDIV_INIT: begin
                r_mean <= r_neg ? -$signed(r_dq[23:0]) : $signed(r_dq[23:0]);
                r_div  <= r_nsq;
                r_drem <= {2'b00, r_dvar[61:32]};
                r_dq   <= {r_dvar[31:0], 16'd0};
            end
            OP_SQRT_INIT: begin
                r_srem <= 26'd0;
                r_root <= 24'd0;
            end
            OP_SQRT_STEP: begin
                r_srem <= w_sge ? 26'(w_rs - w_trial) : w_rs[25:0];
                r_root <= {r_root[22:0], w_sge};
                r_dq   <= {r_dq[45:0], 2'b00};
            end
            OP_RESULT: begin
                r_out.dropped <= r_dropped;
                if (r_count == 16'd0) begin
                    r_out.is_empty <= 1'b1;
                    r_out.count    <= 16'd0;
                    r_out.minimum  <= '0;
                    r_out.maximum  <= '0;
                    r_out.spread   <= 16'd0;
                    r_out.mean_q8  <= '0;
                    r_out.sdev_q8  <= 23'd0;
                end else begin
                    r_out.is_empty <= 1'b0;
                    r_out.count    <= r_count;
                    r_out.minimum  <= r_min;
                    r_out.maximum  <= r_max;
                    r_out.spread   <= 16'($unsigned(r_max) - $unsigned(r_min));
                    r_out.mean_q8  <= r_mean;
                    r_out.sdev_q8  <= r_root[22:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### design/running_sample_statistics_unit.sv
`timescale 1ns / 1ps
// Running sample statistics unit.
// Input channel (i_in_valid / o_in_stall / i_in_item): each item either pushes
// a signed 16-bit sample or clears all statistics.
// Output channel (o_out_valid / i_out_stall / o_out_item): one item per input,
// giving count, min, max, spread, Q8 mean and Q8 population std deviation.
// One item is processed at a time. An empty set (after clear or reset) is
// reported straight from the decide state via the output state. Otherwise an
// item goes through the load, multiply, add and subtract states around one
// shared 32x32 multiplier, a 24-step mean division and a 48-step variance
// division on one radix-2 divider, then a 24-step square root.
// The input is stalled while an item is in work; the next item is accepted
// while the previous result still waits in the output register.
// A stalled result holds; the next result waits until the register frees.
// Reset clears all statistics and empties the output register.
// A push with the count at 65535 is dropped and flagged.
module running_sample_statistics_unit
    import rss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd    w_cmd;
    t_status w_status;

    rss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rss_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_status   (w_status),
        .o_out_item (o_out_item)
    );

endmodule

### design/rss_checker.sv
`timescale 1ns / 1ps
`include "running_sample_statistics_unit_macros.svh"
module rss_checker
    import rss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `RSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `RSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `RSS_ASSERT_NOW(a_empty_count, o_out_valid, o_out_item.is_empty == (o_out_item.count == 16'd0))
    `RSS_ASSERT_NOW(a_spread, o_out_valid && !o_out_item.is_empty, (o_out_item.minimum <= o_out_item.maximum) && (o_out_item.spread == 16'(o_out_item.maximum - o_out_item.minimum)))

endmodule

bind running_sample_statistics_unit rss_checker u_rss_checker (.*);

### dv/tb_running_sample_statistics_unit.sv
`timescale 1ns / 1ps
module tb_running_sample_statistics_unit;
    import rss_pkg::*;

    localparam int      CYCLE_LIMIT = 1500000;
    localparam int      DRAIN_CYCLES = 150;
    localparam logic    ACT_PUSH = 1'b0;
    localparam logic    ACT_CLEAR = 1'b1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    running_sample_statistics_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // statistics state of the predictor
    logic [15:0]        st_count = '0;
    logic signed [15:0] st_min = '0;
    logic signed [15:0] st_max = '0;
    logic signed [32:0] st_sum = '0;
    logic [45:0]        st_sumsq = '0;

    t_in_item  pending_items[$];
    t_out_item expected_stats[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    bit        hold_off = 1'b0;

    function automatic void add_item(t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_out_item predict_stats(t_in_item it);
        t_out_item r;
        logic [63:0] n, mag, ssq, d, nsq, q1, r1, v;
        logic signed [63:0] mean;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            st_count = '0; st_min = '0; st_max = '0; st_sum = '0; st_sumsq = '0;
        end else if (st_count >= MAX_SAMPLES) begin
            r.dropped = 1'b1;
        end else begin
            if (st_count == 0 || it.sample < st_min) st_min = it.sample;
            if (st_count == 0 || it.sample > st_max) st_max = it.sample;
            st_count = st_count + 1;
            st_sum = st_sum + it.sample;
            mag = (it.sample < 0) ? 64'(-$signed(64'(it.sample))) : 64'(it.sample);
            st_sumsq = st_sumsq + 46'(mag * mag);
        end
        if (st_count == 0) begin
            r.is_empty = 1'b1;
            return r;
        end
        n = 64'(st_count);
        r.count = st_count;
        r.minimum = st_min;
        r.maximum = st_max;
        r.spread = 16'(st_max - st_min);
        mean = (64'(st_sum) * 256) / $signed(n);
        r.mean_q8 = 24'(mean);
        mag = st_sum[32] ? 64'(-64'(st_sum)) : 64'(st_sum);
        ssq = mag * mag;
        d = n * 64'(st_sumsq);
        d = (d >= ssq) ? d - ssq : 0;
        nsq = n * n;
        q1 = d / nsq;
        r1 = d % nsq;
        v = (q1 << 16) + ((r1 << 16) / nsq);
        r.sdev_q8 = 23'(isqrt64(v));
        return r;
    endfunction

    function automatic t_in_item make_item(logic act, logic signed [15:0] s);
        t_in_item it;
        it.action = act;
        it.sample = s;
        return it;
    endfunction

    // idle about 20 in 100 except in quiet stretches
    always @(negedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 20);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && !hold_off
                        && (quiet || $urandom_range(99) >= 20)) begin
                    i_in_item <= pending_items[0];
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_stats.insert(expected_stats.size(), predict_stats(i_in_item));
            void'(pending_items.pop_front());
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", o_out_item);
            end else if (o_out_item !== expected_stats[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", expected_stats[0], o_out_item);
                void'(expected_stats.pop_front());
            end else begin
                void'(expected_stats.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_stats.size() > 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        logic signed [15:0] base;
        int k;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_item(make_item(ACT_PUSH, 16'sh7fff));
        add_item(make_item(ACT_PUSH, -16'sd32768));
        add_item(make_item(ACT_PUSH, 16'sd0));
        add_item(make_item(ACT_PUSH, -16'sd1));
        add_item(make_item(ACT_CLEAR, 16'sh5555));
        add_item(make_item(ACT_CLEAR, 16'sh2aaa));
        add_item(make_item(ACT_PUSH, -16'sd32768));
        add_item(make_item(ACT_PUSH, -16'sd32768));
        add_item(make_item(ACT_PUSH, 16'sd7));
        add_item(make_item(ACT_CLEAR, 16'sd0));
        add_item(make_item(ACT_PUSH, 16'sd5));
        add_item(make_item(ACT_PUSH, 16'sd3));
        add_item(make_item(ACT_PUSH, 16'sd9));
        add_item(make_item(ACT_PUSH, -16'sd4));

        wait_drained();
        @(negedge i_clk);
        hold_off = 1'b0;

        for (k = 0; k < 800; k++) begin
            if (k == 300) begin
                wait_drained();
                quiet = 1'b1;
            end
            if (k == 400) quiet = 1'b0;
            if ($urandom_range(99) < 6) begin
                add_item(make_item(ACT_CLEAR, 16'($urandom)));
            end else if ($urandom_range(3) == 0) begin
                add_item(make_item(ACT_PUSH,
                    $urandom_range(1) ? 16'sh7fff : -16'sd32768));
            end else if ($urandom_range(1) == 0) begin
                base = 16'($urandom_range(200)) - 16'sd100;
                add_item(make_item(ACT_PUSH, base));
            end else begin
                add_item(make_item(ACT_PUSH, 16'($urandom)));
            end
            if (pending_items.size() > 4)
                while (pending_items.size() > 2) @(posedge i_clk);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
